[design/cks_pkg.sv]
`timescale 1ns / 1ps

package cks_pkg;

    // Link states
    typedef enum logic [2:0] {
        ST_DISCONNECTED = 3'd0,
        ST_CONNECTING   = 3'd1,
        ST_CONNECTED    = 3'd2,
        ST_RECONNECTING = 3'd3,
        ST_TIMED_OUT    = 3'd4
    } link_state_t;

    // Event codes carried in func
    typedef enum logic [3:0] {
        FN_TICK        = 4'd0,
        FN_CONNECT     = 4'd1,
        FN_DISCONNECT  = 4'd2,
        FN_BYTES_SENT  = 4'd3,
        FN_BYTES_RECV  = 4'd4,
        FN_PKT_SENT    = 4'd5,
        FN_PKT_RECV    = 4'd6,
        FN_PKT_DROPPED = 4'd7,
        FN_RTT         = 4'd8,
        FN_HEARTBEAT   = 4'd9,
        FN_RESET_STATS = 4'd10,
        FN_QUERY       = 4'd11
    } func_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONNECT_TIMEOUT = 3'd0,
        CFG_HB_INTERVAL     = 3'd1,
        CFG_HB_MISS_LIMIT   = 3'd2,
        CFG_RECONNECT_DELAY = 3'd3,
        CFG_MAX_RETRY       = 3'd4,
        CFG_MAX_BPS         = 3'd5,
        CFG_MAX_PACKET      = 3'd6
    } cfg_idx_t;

    localparam logic [15:0] RST_CONNECT_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_HB_INTERVAL     = 16'd1000;
    localparam logic [7:0]  RST_HB_MISS_LIMIT   = 8'd3;
    localparam logic [15:0] RST_RECONNECT_DELAY = 16'd2000;
    localparam logic [7:0]  RST_MAX_RETRY       = 8'd5;
    localparam logic [31:0] RST_MAX_BPS         = 32'd0;
    localparam logic [15:0] RST_MAX_PACKET      = 16'd1400;

    // One second in Q.8 milliseconds
    localparam logic [31:0] WINDOW_Q8 = 32'd256000;

    // Divide by ten: x * ceil(2^31 / 10) >> 31 is exact for x below 2^30
    localparam int          RTT_ACC_W  = 28;
    localparam int          RTT_SHIFT  = 31;
    localparam logic [RTT_ACC_W-1:0] RTT_RECIP = 28'd214748365;

    typedef struct packed {
        logic [15:0] connect_timeout_ms;
        logic [15:0] heartbeat_interval_ms;
        logic [7:0]  heartbeat_miss_limit;
        logic [15:0] reconnect_delay_ms;
        logic [7:0]  max_retry_attempts;
        logic [31:0] max_bytes_per_second;
        logic [15:0] max_packet_bytes;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  func;
        logic [23:0] delta_time;
        logic [31:0] byte_count;
        logic [23:0] rtt_sample;
    } item_t;

    typedef struct packed {
        logic [2:0]  conn_state;
        logic        state_changed;
        logic        can_send;
        logic        size_valid;
        logic [7:0]  retry_count;
        logic [23:0] average_rtt;
        logic [23:0] peak_rtt;
        logic [31:0] total_bytes_out;
        logic [31:0] total_bytes_in;
        logic [31:0] packets_out;
        logic [31:0] packets_in;
        logic [31:0] packets_lost;
    } result_t;

    // Add and clamp at all ones
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

[design/cks_cfg_regs.sv]
`timescale 1ns / 1ps

module cks_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cks_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_wdata,
    output cks_pkg::cfg_t                  cfg
);
    import cks_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.connect_timeout_ms    <= RST_CONNECT_TIMEOUT;
            cfg_reg.heartbeat_interval_ms <= RST_HB_INTERVAL;
            cfg_reg.heartbeat_miss_limit  <= RST_HB_MISS_LIMIT;
            cfg_reg.reconnect_delay_ms    <= RST_RECONNECT_DELAY;
            cfg_reg.max_retry_attempts    <= RST_MAX_RETRY;
            cfg_reg.max_bytes_per_second  <= RST_MAX_BPS;
            cfg_reg.max_packet_bytes      <= RST_MAX_PACKET;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CONNECT_TIMEOUT: cfg_reg.connect_timeout_ms    <= cfg_wdata[15:0];
                CFG_HB_INTERVAL:     cfg_reg.heartbeat_interval_ms <= cfg_wdata[15:0];
                CFG_HB_MISS_LIMIT:   cfg_reg.heartbeat_miss_limit  <= cfg_wdata[7:0];
                CFG_RECONNECT_DELAY: cfg_reg.reconnect_delay_ms    <= cfg_wdata[15:0];
                CFG_MAX_RETRY:       cfg_reg.max_retry_attempts    <= cfg_wdata[7:0];
                CFG_MAX_BPS:         cfg_reg.max_bytes_per_second  <= cfg_wdata;
                CFG_MAX_PACKET:      cfg_reg.max_packet_bytes      <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/cks_in_stage.sv]
`timescale 1ns / 1ps

module cks_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cks_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output cks_pkg::item_t item
);
    import cks_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Take a word whenever the held one is empty or moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[design/cks_engine.sv]
`timescale 1ns / 1ps

module cks_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  cks_pkg::cfg_t    cfg,
    input  cks_pkg::item_t   item,
    input  logic             fire,
    output cks_pkg::result_t result
);
    import cks_pkg::*;

    link_state_t link_state_reg, link_state_next;
    logic [31:0] window_time_reg, window_time_next;
    logic [31:0] window_bytes_reg, window_bytes_next;
    logic [31:0] connect_timer_reg, connect_timer_next;
    logic [31:0] heartbeat_timer_reg, heartbeat_timer_next;
    logic [31:0] retry_timer_reg, retry_timer_next;
    logic [7:0]  attempts_made_reg, attempts_made_next;
    logic [7:0]  attempts_reported_reg, attempts_reported_next;
    logic [23:0] rtt_average_reg, rtt_average_next;
    logic [23:0] rtt_peak_reg, rtt_peak_next;
    logic [31:0] sent_bytes_reg, sent_bytes_next;
    logic [31:0] recv_bytes_reg, recv_bytes_next;
    logic [31:0] sent_pkts_reg, sent_pkts_next;
    logic [31:0] recv_pkts_reg, recv_pkts_next;
    logic [31:0] lost_pkts_reg, lost_pkts_next;

    logic [31:0] dt_ext;
    logic [31:0] win_sum;
    logic [31:0] conn_sum;
    logic [31:0] hb_sum;
    logic [31:0] retry_sum;
    logic [23:0] hb_prod;
    logic [7:0]  attempt_inc;
    logic        may_retry;
    logic [RTT_ACC_W-1:0]   rtt_acc;
    logic [2*RTT_ACC_W-1:0] rtt_prod;
    logic [23:0] rtt_quot;
    logic [32:0] send_sum;

    // Timer sums and limits
    assign dt_ext      = {8'd0, item.delta_time};
    assign win_sum     = sat_add32(window_time_reg, dt_ext);
    assign conn_sum    = sat_add32(connect_timer_reg, dt_ext);
    assign hb_sum      = sat_add32(heartbeat_timer_reg, dt_ext);
    assign retry_sum   = sat_add32(retry_timer_reg, dt_ext);
    assign hb_prod     = {8'd0, cfg.heartbeat_interval_ms} * {16'd0, cfg.heartbeat_miss_limit};
    assign attempt_inc = attempts_made_reg + 8'd1;
    assign may_retry   = (cfg.max_retry_attempts != 8'd0) &&
                         (attempts_made_reg < cfg.max_retry_attempts);

    // Average: (9 * avg + sample + 5) / 10 through a reciprocal multiply
    assign rtt_acc  = {1'b0, rtt_average_reg, 3'b000} + {4'd0, rtt_average_reg}
                    + {4'd0, item.rtt_sample} + 28'd5;
    assign rtt_prod = rtt_acc * RTT_RECIP;
    assign rtt_quot = rtt_prod[RTT_SHIFT +: 24];

    // Next state for one event
    always_comb begin
        link_state_next        = link_state_reg;
        window_time_next       = window_time_reg;
        window_bytes_next      = window_bytes_reg;
        connect_timer_next     = connect_timer_reg;
        heartbeat_timer_next   = heartbeat_timer_reg;
        retry_timer_next       = retry_timer_reg;
        attempts_made_next     = attempts_made_reg;
        attempts_reported_next = attempts_reported_reg;
        rtt_average_next       = rtt_average_reg;
        rtt_peak_next          = rtt_peak_reg;
        sent_bytes_next        = sent_bytes_reg;
        recv_bytes_next        = recv_bytes_reg;
        sent_pkts_next         = sent_pkts_reg;
        recv_pkts_next         = recv_pkts_reg;
        lost_pkts_next         = lost_pkts_reg;

        case (func_t'(item.func))
            FN_TICK: begin
                // Roll the bandwidth window once a second
                if (win_sum >= WINDOW_Q8) begin
                    window_time_next  = win_sum - WINDOW_Q8;
                    window_bytes_next = 32'd0;
                end else begin
                    window_time_next  = win_sum;
                end
                case (link_state_reg)
                    ST_CONNECTING: begin
                        connect_timer_next = conn_sum;
                        if (cfg.connect_timeout_ms != 16'd0 &&
                            conn_sum >= {8'd0, cfg.connect_timeout_ms, 8'd0}) begin
                            if (may_retry) begin
                                retry_timer_next = 32'd0;
                                link_state_next  = ST_RECONNECTING;
                            end else begin
                                link_state_next  = ST_TIMED_OUT;
                            end
                        end
                    end
                    ST_CONNECTED: begin
                        if (cfg.heartbeat_interval_ms != 16'd0) begin
                            heartbeat_timer_next = hb_sum;
                            if (hb_sum >= {hb_prod, 8'd0}) begin
                                if (may_retry) begin
                                    retry_timer_next = 32'd0;
                                    link_state_next  = ST_RECONNECTING;
                                end else begin
                                    link_state_next  = ST_TIMED_OUT;
                                end
                            end
                        end
                    end
                    ST_RECONNECTING: begin
                        retry_timer_next = retry_sum;
                        if (retry_sum >= {8'd0, cfg.reconnect_delay_ms, 8'd0}) begin
                            attempts_made_next     = attempt_inc;
                            attempts_reported_next = attempt_inc;
                            retry_timer_next       = 32'd0;
                            if (attempt_inc >= cfg.max_retry_attempts) begin
                                link_state_next = ST_TIMED_OUT;
                            end else begin
                                connect_timer_next = 32'd0;
                                link_state_next    = ST_CONNECTING;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            FN_CONNECT: begin
                connect_timer_next = 32'd0;
                attempts_made_next = 8'd0;
                link_state_next    = ST_CONNECTING;
            end
            FN_DISCONNECT: begin
                link_state_next = ST_DISCONNECTED;
            end
            FN_BYTES_SENT: begin
                sent_bytes_next   = sent_bytes_reg + item.byte_count;
                window_bytes_next = sat_add32(window_bytes_reg, item.byte_count);
            end
            FN_BYTES_RECV: begin
                recv_bytes_next = recv_bytes_reg + item.byte_count;
            end
            FN_PKT_SENT: begin
                sent_pkts_next = sent_pkts_reg + 32'd1;
            end
            FN_PKT_RECV: begin
                recv_pkts_next = recv_pkts_reg + 32'd1;
                if (link_state_reg == ST_CONNECTING) begin
                    link_state_next = ST_CONNECTED;
                end
            end
            FN_PKT_DROPPED: begin
                lost_pkts_next = lost_pkts_reg + 32'd1;
            end
            FN_RTT: begin
                if (item.rtt_sample > rtt_peak_reg) begin
                    rtt_peak_next = item.rtt_sample;
                end
                rtt_average_next = (rtt_average_reg == 24'd0) ? item.rtt_sample : rtt_quot;
            end
            FN_HEARTBEAT: begin
                heartbeat_timer_next = 32'd0;
            end
            FN_RESET_STATS: begin
                attempts_reported_next = 8'd0;
                rtt_average_next       = 24'd0;
                rtt_peak_next          = 24'd0;
                sent_bytes_next        = 32'd0;
                recv_bytes_next        = 32'd0;
                sent_pkts_next         = 32'd0;
                recv_pkts_next         = 32'd0;
                lost_pkts_next         = 32'd0;
            end
            default: begin
            end
        endcase
    end

    // Result word, checked against the updated window
    assign send_sum = {1'b0, window_bytes_next} + {1'b0, item.byte_count};

    always_comb begin
        result.conn_state      = link_state_next;
        result.state_changed   = (link_state_next != link_state_reg);
        result.can_send        = (cfg.max_bytes_per_second == 32'd0) ||
                                 (send_sum <= {1'b0, cfg.max_bytes_per_second});
        result.size_valid      = (item.byte_count <= {16'd0, cfg.max_packet_bytes});
        result.retry_count     = attempts_reported_next;
        result.average_rtt     = rtt_average_next;
        result.peak_rtt        = rtt_peak_next;
        result.total_bytes_out = sent_bytes_next;
        result.total_bytes_in  = recv_bytes_next;
        result.packets_out     = sent_pkts_next;
        result.packets_in      = recv_pkts_next;
        result.packets_lost    = lost_pkts_next;
    end

    // Commit the state when the word moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_state_reg        <= ST_DISCONNECTED;
            window_time_reg       <= 32'd0;
            window_bytes_reg      <= 32'd0;
            connect_timer_reg     <= 32'd0;
            heartbeat_timer_reg   <= 32'd0;
            retry_timer_reg       <= 32'd0;
            attempts_made_reg     <= 8'd0;
            attempts_reported_reg <= 8'd0;
            rtt_average_reg       <= 24'd0;
            rtt_peak_reg          <= 24'd0;
            sent_bytes_reg        <= 32'd0;
            recv_bytes_reg        <= 32'd0;
            sent_pkts_reg         <= 32'd0;
            recv_pkts_reg         <= 32'd0;
            lost_pkts_reg         <= 32'd0;
        end else if (fire) begin
            link_state_reg        <= link_state_next;
            window_time_reg       <= window_time_next;
            window_bytes_reg      <= window_bytes_next;
            connect_timer_reg     <= connect_timer_next;
            heartbeat_timer_reg   <= heartbeat_timer_next;
            retry_timer_reg       <= retry_timer_next;
            attempts_made_reg     <= attempts_made_next;
            attempts_reported_reg <= attempts_reported_next;
            rtt_average_reg       <= rtt_average_next;
            rtt_peak_reg          <= rtt_peak_next;
            sent_bytes_reg        <= sent_bytes_next;
            recv_bytes_reg        <= recv_bytes_next;
            sent_pkts_reg         <= sent_pkts_next;
            recv_pkts_reg         <= recv_pkts_next;
            lost_pkts_reg         <= lost_pkts_next;
        end
    end

endmodule

[design/cks_out_stage.sv]
`timescale 1ns / 1ps

module cks_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             advance,
    input  cks_pkg::result_t in_result,
    output logic             m_valid,
    input  logic             m_ready,
    output cks_pkg::result_t m_result
);
    import cks_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // Load a new word when the register is empty or being drained
    assign advance = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && advance) begin
            result_reg <= in_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

[design/connection_keepalive_supervisor.sv]
`timescale 1ns / 1ps

// Connection supervisor: tracks link state, keepalive timers, retry count,
// send bandwidth window and traffic/RTT statistics, one event per word.
//
// Input channel (s_valid/s_ready): one event word with func, delta_time,
// byte_count and rtt_sample. Result channel (m_valid/m_ready): exactly one
// result word per event, in order.
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle;
// write only while no event is in flight.
//
// The event sits in the input register while the state update is computed,
// and its result is then presented from the output register. Throughput is
// one event per cycle while the result channel does not stall, set by the
// state update loop (timers, counters, RTT average multiply).
// Reset clears both pipeline registers, returns the link to disconnected with
// zeroed timers and statistics, and loads the default configuration.
// When m_ready is low the result register holds its word; the input
// register still takes one more word, then s_ready drops until the output
// drains.
module connection_keepalive_supervisor (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [cks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_func,
    input  logic [23:0]                   s_delta_time,
    input  logic [31:0]                   s_byte_count,
    input  logic [23:0]                   s_rtt_sample,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_conn_state,
    output logic                          m_state_changed,
    output logic                          m_can_send,
    output logic                          m_size_valid,
    output logic [7:0]                    m_retry_count,
    output logic [23:0]                   m_average_rtt,
    output logic [23:0]                   m_peak_rtt,
    output logic [31:0]                   m_total_bytes_out,
    output logic [31:0]                   m_total_bytes_in,
    output logic [31:0]                   m_packets_out,
    output logic [31:0]                   m_packets_in,
    output logic [31:0]                   m_packets_lost
);
    import cks_pkg::*;

    cfg_t    cfg;
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    fire;
    result_t result;
    result_t m_result;

    assign s_item = '{func: s_func, delta_time: s_delta_time,
                      byte_count: s_byte_count, rtt_sample: s_rtt_sample};

    // Commit an event when it moves into the result register
    assign fire = item_valid && advance;

    cks_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cks_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cks_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .fire    (fire),
        .result  (result)
    );

    cks_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_valid),
        .advance   (advance),
        .in_result (result),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    assign m_conn_state      = m_result.conn_state;
    assign m_state_changed   = m_result.state_changed;
    assign m_can_send        = m_result.can_send;
    assign m_size_valid      = m_result.size_valid;
    assign m_retry_count     = m_result.retry_count;
    assign m_average_rtt     = m_result.average_rtt;
    assign m_peak_rtt        = m_result.peak_rtt;
    assign m_total_bytes_out = m_result.total_bytes_out;
    assign m_total_bytes_in  = m_result.total_bytes_in;
    assign m_packets_out     = m_result.packets_out;
    assign m_packets_in      = m_result.packets_in;
    assign m_packets_lost    = m_result.packets_lost;

endmodule

[design/cks_checker.sv]
`timescale 1ns / 1ps

module cks_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [cks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [3:0]                    s_func,
    input  logic [23:0]                   s_delta_time,
    input  logic [31:0]                   s_byte_count,
    input  logic [23:0]                   s_rtt_sample,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [2:0]                    m_conn_state,
    input  logic                          m_state_changed,
    input  logic                          m_can_send,
    input  logic                          m_size_valid,
    input  logic [7:0]                    m_retry_count,
    input  logic [23:0]                   m_average_rtt,
    input  logic [23:0]                   m_peak_rtt,
    input  logic [31:0]                   m_total_bytes_out,
    input  logic [31:0]                   m_total_bytes_in,
    input  logic [31:0]                   m_packets_out,
    input  logic [31:0]                   m_packets_in,
    input  logic [31:0]                   m_packets_lost
);
    import cks_pkg::*;

    logic [2:0] last_state_reg;

    // Track the state of the last delivered word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_state_reg <= ST_DISCONNECTED;
        end else if (m_valid && m_ready) begin
            last_state_reg <= m_conn_state;
        end
    end

    // No result word right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_conn_state) &&
            $stable(m_total_bytes_out) && $stable(m_average_rtt))
        else $error("stalled result word changed");

    // state_changed flags a change from the previous delivered state
    a_change_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> m_state_changed == (m_conn_state != last_state_reg))
        else $error("state_changed disagrees with state sequence");

    // The RTT average never exceeds the peak sample
    a_avg_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_average_rtt <= m_peak_rtt)
        else $error("average RTT above peak RTT");

endmodule

bind connection_keepalive_supervisor cks_checker u_cks_checker (.*);

[sim/tb_connection_keepalive_supervisor.sv]
`timescale 1ns / 1ps

module tb_connection_keepalive_supervisor;

    import cks_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned PHASE_EVENTS  = 175;
    localparam int unsigned NUM_PHASES    = 6;
    localparam logic [31:0] ONE_SECOND_Q8 = 32'd256000;

    localparam cfg_t DEFAULT_SETTINGS = '{
        connect_timeout_ms:    16'd5000,
        heartbeat_interval_ms: 16'd1000,
        heartbeat_miss_limit:  8'd3,
        reconnect_delay_ms:    16'd2000,
        max_retry_attempts:    8'd5,
        max_bytes_per_second:  32'd0,
        max_packet_bytes:      16'd1400
    };

    // Tracks the supervisor state and holds the results still owed by the block
    class link_scoreboard;
        cfg_t        cfg;
        link_state_t link;
        logic [31:0] window_time, window_bytes;
        logic [31:0] connect_timer, heartbeat_timer, retry_timer;
        logic [7:0]  attempts_made, attempts_reported;
        logic [23:0] rtt_avg, rtt_peak;
        logic [31:0] sent_bytes, recv_bytes, sent_pkts, recv_pkts, lost_pkts;
        result_t     owed[$];

        int unsigned errors, checked, state_changes, timeouts, retries, window_rolls;

        function new();
            cfg             = DEFAULT_SETTINGS;
            link            = ST_DISCONNECTED;
            window_time     = '0;
            window_bytes    = '0;
            connect_timer   = '0;
            heartbeat_timer = '0;
            retry_timer     = '0;
            attempts_made   = '0;
            clear_stats();
        endfunction

        function logic [31:0] clamp_sum(logic [31:0] a, logic [31:0] b);
            logic [32:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        endfunction

        function void clear_stats();
            attempts_reported = '0;
            rtt_avg           = '0;
            rtt_peak          = '0;
            sent_bytes        = '0;
            recv_bytes        = '0;
            sent_pkts         = '0;
            recv_pkts         = '0;
            lost_pkts         = '0;
        endfunction

        // Link declared lost: retry if attempts remain, else give up
        function void link_lost();
            if (cfg.max_retry_attempts != 0 && attempts_made < cfg.max_retry_attempts) begin
                retry_timer = '0;
                link        = ST_RECONNECTING;
            end else begin
                link = ST_TIMED_OUT;
            end
        endfunction

        function void start_retry();
            attempts_made     = attempts_made + 8'd1;
            attempts_reported = attempts_made;
            retry_timer       = '0;
            retries++;
            if (attempts_made >= cfg.max_retry_attempts) begin
                link = ST_TIMED_OUT;
            end else begin
                connect_timer = '0;
                link          = ST_CONNECTING;
            end
        endfunction

        // Advance the bandwidth window and whichever timer the state runs
        function void advance_time(logic [31:0] dt);
            logic [63:0] hb_limit;
            window_time = clamp_sum(window_time, dt);
            if (window_time >= ONE_SECOND_Q8) begin
                window_time  = window_time - ONE_SECOND_Q8;
                window_bytes = '0;
                window_rolls++;
            end
            case (link)
                ST_CONNECTING: begin
                    connect_timer = clamp_sum(connect_timer, dt);
                    if (cfg.connect_timeout_ms != 0 &&
                        connect_timer >= {8'd0, cfg.connect_timeout_ms, 8'd0})
                        link_lost();
                end
                ST_CONNECTED: begin
                    if (cfg.heartbeat_interval_ms != 0) begin
                        hb_limit = ({48'd0, cfg.heartbeat_interval_ms} *
                                    {56'd0, cfg.heartbeat_miss_limit}) << 8;
                        heartbeat_timer = clamp_sum(heartbeat_timer, dt);
                        if ({32'd0, heartbeat_timer} >= hb_limit)
                            link_lost();
                    end
                end
                ST_RECONNECTING: begin
                    retry_timer = clamp_sum(retry_timer, dt);
                    if (retry_timer >= {8'd0, cfg.reconnect_delay_ms, 8'd0})
                        start_retry();
                end
                default: ;
            endcase
        endfunction

        // Fold a sample into the 0.9/0.1 average, rounded half up
        function void fold_rtt(logic [23:0] sample);
            logic [63:0] acc;
            if (sample > rtt_peak)
                rtt_peak = sample;
            if (rtt_avg == 0) begin
                rtt_avg = sample;
            end else begin
                acc     = ({40'd0, rtt_avg} * 64'd9 + {40'd0, sample} + 64'd5) / 64'd10;
                rtt_avg = acc[23:0];
            end
        endfunction

        // Apply one accepted event word and queue the result it must produce
        function void note_event(item_t word);
            result_t     want;
            link_state_t prior;
            prior = link;
            case (word.func)
                FN_TICK:        advance_time({8'd0, word.delta_time});
                FN_CONNECT: begin
                    connect_timer = '0;
                    attempts_made = '0;
                    link          = ST_CONNECTING;
                end
                FN_DISCONNECT:  link = ST_DISCONNECTED;
                FN_BYTES_SENT: begin
                    sent_bytes   = sent_bytes + word.byte_count;
                    window_bytes = clamp_sum(window_bytes, word.byte_count);
                end
                FN_BYTES_RECV:  recv_bytes = recv_bytes + word.byte_count;
                FN_PKT_SENT:    sent_pkts  = sent_pkts + 32'd1;
                FN_PKT_RECV: begin
                    recv_pkts = recv_pkts + 32'd1;
                    if (link == ST_CONNECTING)
                        link = ST_CONNECTED;
                end
                FN_PKT_DROPPED: lost_pkts = lost_pkts + 32'd1;
                FN_RTT:         fold_rtt(word.rtt_sample);
                FN_HEARTBEAT:   heartbeat_timer = '0;
                FN_RESET_STATS: clear_stats();
                default: ;
            endcase

            if (link != prior) begin
                state_changes++;
                if (link == ST_TIMED_OUT)
                    timeouts++;
            end

            want.conn_state      = link;
            want.state_changed   = (link != prior);
            want.can_send        = (cfg.max_bytes_per_second == 0) ||
                                   ({32'd0, window_bytes} + {32'd0, word.byte_count} <=
                                    {32'd0, cfg.max_bytes_per_second});
            want.size_valid      = (word.byte_count <= {16'd0, cfg.max_packet_bytes});
            want.retry_count     = attempts_reported;
            want.average_rtt     = rtt_avg;
            want.peak_rtt        = rtt_peak;
            want.total_bytes_out = sent_bytes;
            want.total_bytes_in  = recv_bytes;
            want.packets_out     = sent_pkts;
            want.packets_in      = recv_pkts;
            want.packets_lost    = lost_pkts;
            owed.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Match a result word against the oldest owed result
        function void check_result(result_t got);
            result_t want;
            if (owed.size() == 0) begin
                $error("result word with nothing outstanding: conn_state %0d", got.conn_state);
                errors++;
                return;
            end
            want = owed.pop_front();
            checked++;
            compare_field("conn_state",      want.conn_state,      got.conn_state);
            compare_field("state_changed",   want.state_changed,   got.state_changed);
            compare_field("can_send",        want.can_send,        got.can_send);
            compare_field("size_valid",      want.size_valid,      got.size_valid);
            compare_field("retry_count",     want.retry_count,     got.retry_count);
            compare_field("average_rtt",     want.average_rtt,     got.average_rtt);
            compare_field("peak_rtt",        want.peak_rtt,        got.peak_rtt);
            compare_field("total_bytes_out", want.total_bytes_out, got.total_bytes_out);
            compare_field("total_bytes_in",  want.total_bytes_in,  got.total_bytes_in);
            compare_field("packets_out",     want.packets_out,     got.packets_out);
            compare_field("packets_in",      want.packets_in,      got.packets_in);
            compare_field("packets_lost",    want.packets_lost,    got.packets_lost);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [31:0]          cfg_wdata    = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [3:0]           s_func       = '0;
    logic [23:0]          s_delta_time = '0;
    logic [31:0]          s_byte_count = '0;
    logic [23:0]          s_rtt_sample = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [2:0]           m_conn_state;
    logic                 m_state_changed;
    logic                 m_can_send;
    logic                 m_size_valid;
    logic [7:0]           m_retry_count;
    logic [23:0]          m_average_rtt;
    logic [23:0]          m_peak_rtt;
    logic [31:0]          m_total_bytes_out;
    logic [31:0]          m_total_bytes_in;
    logic [31:0]          m_packets_out;
    logic [31:0]          m_packets_in;
    logic [31:0]          m_packets_lost;

    link_scoreboard sb = new();
    int unsigned    cycles        = 0;
    int unsigned    events_sent   = 0;
    int unsigned    no_gap_left   = 0;
    bit             held_long     = 1'b0;

    connection_keepalive_supervisor u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_delta_time      (s_delta_time),
        .s_byte_count      (s_byte_count),
        .s_rtt_sample      (s_rtt_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_conn_state      (m_conn_state),
        .m_state_changed   (m_state_changed),
        .m_can_send        (m_can_send),
        .m_size_valid      (m_size_valid),
        .m_retry_count     (m_retry_count),
        .m_average_rtt     (m_average_rtt),
        .m_peak_rtt        (m_peak_rtt),
        .m_total_bytes_out (m_total_bytes_out),
        .m_total_bytes_in  (m_total_bytes_in),
        .m_packets_out     (m_packets_out),
        .m_packets_in      (m_packets_in),
        .m_packets_lost    (m_packets_lost)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_connection_keepalive_supervisor: done, errors");
            $finish;
        end
    end

    // Check every result word taken by the receiver
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.conn_state      = m_conn_state;
            got.state_changed   = m_state_changed;
            got.can_send        = m_can_send;
            got.size_valid      = m_size_valid;
            got.retry_count     = m_retry_count;
            got.average_rtt     = m_average_rtt;
            got.peak_rtt        = m_peak_rtt;
            got.total_bytes_out = m_total_bytes_out;
            got.total_bytes_in  = m_total_bytes_in;
            got.packets_out     = m_packets_out;
            got.packets_in      = m_packets_in;
            got.packets_lost    = m_packets_lost;
            sb.check_result(got);
        end
    end

    // Receiver: free-running stretches, short random stalls, rare long hold-offs
    initial begin
        int unsigned r;
        wait (aresetn);
        forever begin
            r = $urandom_range(0, 99);
            if ((!held_long && sb.checked >= 300) || r == 0) begin
                held_long = 1'b1;
                m_ready <= 1'b0;
                repeat ($urandom_range(40, 120)) @(posedge aclk);
            end else if (r < 15) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge aclk);
            end else if (r < 22) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(2, 6)) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
                @(posedge aclk);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gap_left != 0) begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            no_gap_left = $urandom_range(20, 60);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one event word, hold it until taken, then record it
    task automatic send_event(item_t word);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= word.func;
        s_delta_time <= word.delta_time;
        s_byte_count <= word.byte_count;
        s_rtt_sample <= word.rtt_sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_event(word);
        events_sent++;
    endtask

    // Stop offering and wait until every owed result has come back
    task automatic quiesce();
        s_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [31:0] reg_value(cfg_t c, cfg_idx_t idx);
        case (idx)
            CFG_CONNECT_TIMEOUT: return {16'($urandom), c.connect_timeout_ms};
            CFG_HB_INTERVAL:     return {16'($urandom), c.heartbeat_interval_ms};
            CFG_HB_MISS_LIMIT:   return {24'($urandom), c.heartbeat_miss_limit};
            CFG_RECONNECT_DELAY: return {16'($urandom), c.reconnect_delay_ms};
            CFG_MAX_RETRY:       return {24'($urandom), c.max_retry_attempts};
            CFG_MAX_BPS:         return c.max_bytes_per_second;
            CFG_MAX_PACKET:      return {16'($urandom), c.max_packet_bytes};
            default:             return '0;
        endcase
    endfunction

    // Write all registers back to back; unused upper data bits carry noise
    task automatic load_settings(cfg_t c);
        cfg_idx_t idx;
        idx = idx.first();
        do begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= reg_value(c, idx);
            @(posedge aclk);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_we <= 1'b0;
        sb.cfg = c;
    endtask

    task automatic pick_phase(input int unsigned p, output cfg_t c, output int unsigned span);
        case (p)
            0: begin
                c = '{16'd40, 16'd10, 8'd3, 16'd20, 8'd4, 32'd3000, 16'd1400};
                span = 256 * 25;
            end
            1: begin
                c = '{16'd0, 16'd0, 8'd0, 16'd0, 8'd0, 32'd0, 16'd0};
                span = 256 * 600;
            end
            2: begin
                c = '{16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF};
                span = 24'hFF_FFFF;
            end
            3: begin
                // zero miss limit: first connected tick declares the link lost
                c = '{16'd1, 16'd5, 8'd0, 16'd0, 8'd1, 32'd1, 16'd1};
                span = 512;
            end
            4: begin
                c = '{16'd2, 16'd1, 8'd255, 16'd1, 8'd255, 32'd100000, 16'd0};
                span = 256 * 3;
            end
            default: begin
                c.connect_timeout_ms    = 16'($urandom_range(1, 300));
                c.heartbeat_interval_ms = 16'($urandom_range(1, 100));
                c.heartbeat_miss_limit  = 8'($urandom_range(0, 6));
                c.reconnect_delay_ms    = 16'($urandom_range(0, 200));
                c.max_retry_attempts    = 8'($urandom_range(0, 8));
                c.max_bytes_per_second  = $urandom_range(0, 20000);
                c.max_packet_bytes      = 16'($urandom_range(0, 3000));
                span = $urandom_range(256, 256 * 100);
            end
        endcase
    endtask

    // Bias the event code so sessions get past connecting and into timeouts
    function automatic logic [3:0] pick_func();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (sb.link)
            ST_DISCONNECTED, ST_TIMED_OUT: if (r < 45) return FN_CONNECT;
            ST_CONNECTING: begin
                if (r < 45) return FN_TICK;
                if (r < 65) return FN_PKT_RECV;
            end
            ST_CONNECTED: begin
                if (r < 40) return FN_TICK;
                if (r < 55) return FN_HEARTBEAT;
            end
            ST_RECONNECTING: if (r < 55) return FN_TICK;
            default: ;
        endcase
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic item_t make_event(int unsigned span);
        item_t       word;
        int unsigned r;
        word.func = pick_func();

        r = $urandom_range(0, 99);
        if (r < 70)      word.delta_time = 24'($urandom_range(0, span));
        else if (r < 80) word.delta_time = 24'($urandom);
        else if (r < 85) word.delta_time = 24'hFF_FFFF;
        else if (r < 90) word.delta_time = '0;
        else             word.delta_time = 24'($urandom_range(255000, 257000));

        r = $urandom_range(0, 99);
        if (r < 35) begin
            word.byte_count = $urandom_range(0, sb.cfg.max_packet_bytes + 2);
        end else if (r < 50) begin
            // land on the edge of the remaining bandwidth
            if (sb.cfg.max_bytes_per_second != 0 &&
                sb.cfg.max_bytes_per_second >= sb.window_bytes)
                word.byte_count = sb.cfg.max_bytes_per_second - sb.window_bytes +
                                  32'($urandom_range(0, 1));
            else
                word.byte_count = $urandom_range(0, 5000);
        end else if (r < 75) begin
            word.byte_count = $urandom;
        end else if (r < 82) begin
            word.byte_count = 32'hFFFF_FFFF;
        end else if (r < 88) begin
            word.byte_count = '0;
        end else begin
            word.byte_count = {16'd0, sb.cfg.max_packet_bytes} + 32'($urandom_range(0, 1));
        end

        r = $urandom_range(0, 99);
        if (r < 50)      word.rtt_sample = 24'($urandom_range(0, 65535));
        else if (r < 80) word.rtt_sample = 24'($urandom);
        else if (r < 90) word.rtt_sample = 24'hFF_FFFF;
        else             word.rtt_sample = '0;
        return word;
    endfunction

    function automatic item_t event_word(logic [3:0] f, logic [23:0] dt, logic [31:0] bytes,
                                         logic [23:0] rtt);
        item_t word;
        word.func       = f;
        word.delta_time = dt;
        word.byte_count = bytes;
        word.rtt_sample = rtt;
        return word;
    endfunction

    initial begin
        cfg_t        settings;
        int unsigned span;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at reset settings
        send_event(event_word(FN_QUERY,       24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_BYTES_SENT,  24'd0,        32'hFFFF_FFFF, 24'd0));
        send_event(event_word(FN_BYTES_SENT,  24'd0,        32'd1,         24'd0));
        send_event(event_word(FN_BYTES_RECV,  24'd0,        32'hFFFF_FFFF, 24'd0));
        send_event(event_word(FN_PKT_SENT,    24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_PKT_RECV,    24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_PKT_DROPPED, 24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_RTT,         24'd0,        32'd0,         24'h100));
        send_event(event_word(FN_RTT,         24'd0,        32'd0,         24'hFF_FFFF));
        send_event(event_word(FN_RTT,         24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_CONNECT,     24'd0,        32'd0,         24'd0));
        // connect timeout into reconnecting, with a window roll
        send_event(event_word(FN_TICK,        24'hFF_FFFF, 32'd0,         24'd0));
        // reconnect delay expires: retry back to connecting
        send_event(event_word(FN_TICK,        24'hFF_FFFF, 32'd0,         24'd0));
        send_event(event_word(FN_PKT_RECV,    24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_HEARTBEAT,   24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_TICK,        24'd0,        32'd0,         24'd0));
        // heartbeat misses run out
        send_event(event_word(FN_TICK,        24'hFF_FFFF, 32'd0,         24'd0));
        send_event(event_word(FN_DISCONNECT,  24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_RESET_STATS, 24'd0,        32'd0,         24'd0));
        send_event(event_word(4'd12,          24'hFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
        send_event(event_word(4'd15,          24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_QUERY,       24'd0,        32'd1400,      24'd0));
        send_event(event_word(FN_QUERY,       24'd0,        32'd1401,      24'd0));
        send_event(event_word(FN_CONNECT,     24'd0,        32'd0,         24'd0));
        send_event(event_word(FN_PKT_RECV,    24'd0,        32'd0,         24'd0));
        quiesce();

        // Random sessions under a series of settings
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            pick_phase(p, settings, span);
            load_settings(settings);
            repeat (PHASE_EVENTS) send_event(make_event(span));
            quiesce();
        end

        $display("summary: %0d events, %0d results checked, %0d state changes",
                 events_sent, sb.checked, sb.state_changes);
        $display("summary: %0d timeouts, %0d retries, %0d window rolls, %0d settings",
                 sb.timeouts, sb.retries, sb.window_rolls, NUM_PHASES + 1);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("tb_connection_keepalive_supervisor: done, clean");
        else
            $display("tb_connection_keepalive_supervisor: done, errors");
        $finish;
    end

endmodule
